### hdl/pfa_pkg.sv
// Package of the page frame allocator: sequencer state type, status and
// command codes, register indexes and fixed widths. No dependencies.
package pfa_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int COUNT_W    = 8;
   localparam int STATUS_W   = 3;
   localparam int ADDR_W     = 32;

   localparam logic [STATUS_W-1:0] STATUS_SUCCESS     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_STACK_FULL  = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic REG_REGION_BASE = 1'b0;
   localparam logic REG_PAGE_COUNT  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POP_CHK,
      ST_MAP_CHK,
      ST_SCAN,
      ST_MARK,
      ST_FREE_CHK,
      ST_FREE_MAP
   } state_type;

endpackage

### hdl/pfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the free-page stack and the in-use bitmap. No dependencies.
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/page_frame_allocator_unit.sv
// Top level of the page frame allocator: APB register port, command
// sequencer and the two RAMs. Depends on pfa_pkg and pfa_ram.
//
// Usage: a transaction is issued by raising start with req_command,
// req_page_address and req_page_run while busy is low. Unless it is answered
// at once, the block then raises busy, works through the request with one
// sequencer and one compare/add datapath, and shows rsp_status and
// rsp_result_address for exactly one cycle with rsp_valid high. The receiver
// cannot stall, so a response is never held; a new transaction may start in
// the cycle the response is shown.
// Sequencing: an allocate of zero pages is answered from idle; a single-page
// allocate pops stack entries (up to page_count of them) and checks each in
// the bitmap; a multi-page allocate reads the bitmap, up to page_count reads,
// one per cycle, then marks the run; a free checks the range, then reads the
// bitmap, and clears a multi-page run. The bitmap RAM read port gives one
// read per cycle.
// Reset and every write of page_count start a clearing pass over all MAX_PAGES
// entries that refills the stack and clears the bitmap; busy is high
// during it, while register writes are still taken.
module page_frame_allocator_unit #(
   parameter int MAX_PAGES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_page_address,
   input  logic [7:0]  req_page_run,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_address,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import pfa_pkg::*;

   localparam int IW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CW     = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
   localparam int RST_PC = (MAX_PAGES >= 128) ? 128 : MAX_PAGES;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [COUNT_W-1:0]  pc_ff, pc_in;
   logic [COUNT_W-1:0]  sc_ff, sc_in;
   logic [IW-1:0]       clr_ff, clr_in;
   logic                cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [COUNT_W-1:0]  run_ff, run_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       mk_ff, mk_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  ra_ff, ra_in;
   logic [COUNT_W-1:0]  cons_ff, cons_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;

   logic          stk_we, map_we, map_wd;
   logic [IW-1:0] stk_wa, stk_wd, stk_ra, stk_rd;
   logic [IW-1:0] map_wa, map_ra;
   logic          map_rd;

   // Register port decode and page count clamping.
   logic               csr_wr, count_wr, base_wr;
   logic [COUNT_W-1:0] pc_clamp;

   assign csr_wr   = psel && penable && pwrite && pready;
   assign count_wr = csr_wr && (paddr[2] == REG_PAGE_COUNT);
   assign base_wr  = csr_wr && (paddr[2] == REG_REGION_BASE);

   always_comb begin
      if (pwdata[COUNT_W-1:0] == '0) begin
         pc_clamp = COUNT_W'(1);
      end else if (CW'(pwdata[COUNT_W-1:0]) > CW'(MAX_PAGES)) begin
         pc_clamp = COUNT_W'(MAX_PAGES);
      end else begin
         pc_clamp = pwdata[COUNT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_PAGE_COUNT) ? {{(32-COUNT_W){1'b0}}, pc_ff} : base_ff;

   // Shared conditions of the datapath.
   logic               accept, sc_zero, clr_last, pop_ok;
   logic               found, scan_last, mark_last, out_range, stack_full;
   logic [COUNT_W-1:0] sc_dec, cons_next, scan_start;
   logic [CW-1:0]      sc_ext, sc_dec_ext, ra_ext, start_ext;
   logic [ADDR_W-1:0]  offset;
   logic [20:0]        fidx;
   logic [ADDR_W-1:0]  page_addr;

   assign accept     = start && !busy;
   assign sc_zero    = (sc_ff == '0);
   assign sc_dec     = sc_ff - COUNT_W'(1);
   assign sc_ext     = CW'(sc_ff);
   assign sc_dec_ext = CW'(sc_dec);
   assign ra_ext     = CW'(ra_ff);
   assign clr_last   = (clr_ff == IW'(MAX_PAGES - 1));
   assign pop_ok     = (CW'(idx_ff) < CW'(pc_ff)) && !map_rd;

   assign cons_next  = map_rd ? '0 : COUNT_W'({1'b0, cons_ff} + 9'd1);
   assign found      = !map_rd && (({1'b0, cons_ff} + 9'd1) == {1'b0, run_ff});
   assign scan_last  = (ra_ff == pc_ff);
   assign scan_start = ra_ff - run_ff;
   assign start_ext  = CW'(scan_start);
   assign mark_last  = (cnt_ff == COUNT_W'(1));

   assign offset     = addr_ff - base_ff;
   assign fidx       = {1'b0, offset[ADDR_W-1:PAGE_SHIFT]};
   assign out_range  = (addr_ff < base_ff) || (fidx >= 21'(pc_ff)) ||
                       ((fidx + 21'(run_ff)) > 21'(pc_ff));
   assign stack_full = (sc_ff >= pc_ff);

   assign page_addr  = base_ff + (ADDR_W'(idx_ff) << PAGE_SHIFT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_FREE) begin
                  state_in = ST_FREE_CHK;
               end else if (req_page_run == COUNT_W'(1)) begin
                  if (!sc_zero) state_in = ST_POP_CHK;
               end else if (req_page_run != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_POP_CHK: begin
            state_in = ST_MAP_CHK;
         end
         ST_MAP_CHK: begin
            if (pop_ok || sc_zero) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_POP_CHK;
            end
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_MARK;
            end else if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (mark_last) state_in = ST_IDLE;
         end
         ST_FREE_CHK: begin
            if (out_range) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FREE_MAP;
            end
         end
         ST_FREE_MAP: begin
            if (map_rd && (run_ff > COUNT_W'(1))) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (count_wr) state_in = ST_CLEAR;
   end

   // Datapath, RAM control and response.
   always_comb begin
      base_in       = base_ff;
      pc_in         = pc_ff;
      sc_in         = sc_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      run_in        = run_ff;
      idx_in        = idx_ff;
      mk_in         = mk_ff;
      cnt_in        = cnt_ff;
      ra_in         = ra_ff;
      cons_in       = cons_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      stk_we        = 1'b0;
      stk_wa        = '0;
      stk_wd        = '0;
      stk_ra        = '0;
      map_we        = 1'b0;
      map_wa        = '0;
      map_wd        = 1'b0;
      map_ra        = '0;
      case (state_ff)
         ST_CLEAR: begin
            stk_we = 1'b1;
            stk_wa = clr_ff;
            stk_wd = clr_ff;
            map_we = 1'b1;
            map_wa = clr_ff;
            map_wd = 1'b0;
            clr_in = clr_ff + IW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               addr_in = req_page_address;
               run_in  = req_page_run;
               if (req_command == CMD_ALLOC) begin
                  if (req_page_run == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_NO_MEMORY;
                     rsp_addr_in   = '0;
                  end else if (req_page_run == COUNT_W'(1)) begin
                     if (sc_zero) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NO_MEMORY;
                        rsp_addr_in   = '0;
                     end else begin
                        stk_ra = sc_dec_ext[IW-1:0];
                        sc_in  = sc_dec;
                     end
                  end else begin
                     map_ra  = '0;
                     ra_in   = COUNT_W'(1);
                     cons_in = '0;
                  end
               end
            end
         end
         ST_POP_CHK: begin
            idx_in = stk_rd;
            map_ra = stk_rd;
         end
         ST_MAP_CHK: begin
            if (pop_ok) begin
               map_we        = 1'b1;
               map_wa        = idx_ff;
               map_wd        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_SUCCESS;
               rsp_addr_in   = page_addr;
            end else if (sc_zero) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_MEMORY;
               rsp_addr_in   = '0;
            end else begin
               stk_ra = sc_dec_ext[IW-1:0];
               sc_in  = sc_dec;
            end
         end
         ST_SCAN: begin
            // The bitmap word arriving now belongs to page ra_ff - 1.
            cons_in = cons_next;
            if (found) begin
               idx_in = start_ext[IW-1:0];
               mk_in  = start_ext[IW-1:0];
               cnt_in = run_ff;
            end else if (scan_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_MEMORY;
               rsp_addr_in   = '0;
            end else begin
               map_ra = ra_ext[IW-1:0];
               ra_in  = ra_ff + COUNT_W'(1);
            end
         end
         ST_MARK: begin
            map_we = 1'b1;
            map_wa = mk_ff;
            map_wd = (cmd_ff == CMD_ALLOC);
            mk_in  = mk_ff + IW'(1);
            cnt_in = cnt_ff - COUNT_W'(1);
            if (mark_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_SUCCESS;
               rsp_addr_in   = (cmd_ff == CMD_ALLOC) ? page_addr : '0;
            end
         end
         ST_FREE_CHK: begin
            if (out_range) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_INVALID;
               rsp_addr_in   = '0;
            end else begin
               idx_in = fidx[IW-1:0];
               map_ra = fidx[IW-1:0];
            end
         end
         ST_FREE_MAP: begin
            rsp_addr_in = '0;
            if (!map_rd) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_IN_USE;
            end else if (run_ff == COUNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               if (stack_full) begin
                  rsp_status_in = STATUS_STACK_FULL;
               end else begin
                  map_we        = 1'b1;
                  map_wa        = idx_ff;
                  map_wd        = 1'b0;
                  stk_we        = 1'b1;
                  stk_wa        = sc_ext[IW-1:0];
                  stk_wd        = idx_ff;
                  sc_in         = sc_ff + COUNT_W'(1);
                  rsp_status_in = STATUS_SUCCESS;
               end
            end else if (run_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_SUCCESS;
            end else begin
               mk_in  = idx_ff;
               cnt_in = run_ff;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      if (base_wr) base_in = pwdata;
      if (count_wr) begin
         pc_in  = pc_clamp;
         sc_in  = pc_clamp;
         clr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         pc_ff        <= COUNT_W'(RST_PC);
         sc_ff        <= COUNT_W'(RST_PC);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         pc_ff        <= pc_in;
         sc_ff        <= sc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      run_ff        <= run_in;
      idx_ff        <= idx_in;
      mk_ff         <= mk_in;
      cnt_ff        <= cnt_in;
      ra_ff         <= ra_in;
      cons_ff       <= cons_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   pfa_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   pfa_ram #(
      .WIDTH (1),
      .DEPTH (MAX_PAGES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_addr (map_ra),
      .rd_data (map_rd)
   );

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

### bench/page_frame_allocator_unit_test.sv
// Self-checking bench for page_frame_allocator_unit: directed table, then random
// allocate/free traffic under several region settings, checked against a predictor.
// Depends on pfa_pkg and the RTL of the allocator.
module page_frame_allocator_unit_test;
   import pfa_pkg::*;

   localparam int MAX_PAGES      = 128;
   localparam int CLOCK_PERIOD   = 8;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int DIRECTED_ROWS  = 30;
   localparam int SEGMENTS       = 6;
   localparam int SEGMENT_ITEMS  = 75;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] address;
   } frame_reply_type;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   // For a register row, command holds the register index and address the value.
   typedef struct packed {
      row_kind_type kind;
      logic         command;
      logic [31:0]  address;
      logic [7:0]   run;
      logic         by_value;
      logic [2:0]   status;
      logic [31:0]  result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = CMD_ALLOC;
   logic [31:0] req_page_address = '0;
   logic [7:0]  req_page_run = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_result_address;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Shadow of the allocator state.
   logic [31:0]          region_base_shadow;
   int unsigned          managed_count;
   int unsigned          free_depth;
   logic [6:0]           free_pages [MAX_PAGES];
   logic [MAX_PAGES-1:0] page_in_use;

   frame_reply_type owed_replies [$];
   logic            typed_check = 1'b0;
   frame_reply_type typed_reply = '0;
   int              mismatches = 0;
   int              replies_checked = 0;
   int              requests_sent = 0;
   int              settings_applied = 0;
   int              status_seen [5] = '{default: 0};

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd0,   1'b1, STATUS_NO_MEMORY,  32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'hFFFF_FFFF, 8'd1,   1'b1, STATUS_SUCCESS,    32'h0007_F000},
      '{ROW_ITEM, CMD_FREE,  32'h0007_F000, 8'd1,   1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0007_F000, 8'd1,   1'b1, STATUS_NOT_IN_USE, 32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd128, 1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd2,   1'b1, STATUS_NO_MEMORY,  32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd1,   1'b1, STATUS_NO_MEMORY,  32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0000_5123, 8'd1,   1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0008_0000, 8'd1,   1'b1, STATUS_INVALID,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0007_E000, 8'd3,   1'b1, STATUS_INVALID,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0000_0000, 8'd0,   1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0001_0000, 8'd16,  1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd20,  1'b0, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd16,  1'b0, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd1,   1'b1, STATUS_SUCCESS,    32'h0000_5000},
      '{ROW_ITEM, CMD_FREE,  32'hFFFF_FFFF, 8'd255, 1'b1, STATUS_INVALID,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0000_0000, 8'd255, 1'b1, STATUS_INVALID,    32'h0},
      '{ROW_WRITE, REG_PAGE_COUNT, 32'h0000_0000, 8'd0, 1'b0, STATUS_SUCCESS, 32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd1,   1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd1,   1'b1, STATUS_NO_MEMORY,  32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0000_0FFF, 8'd1,   1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0000_1000, 8'd1,   1'b1, STATUS_INVALID,    32'h0},
      '{ROW_WRITE, REG_PAGE_COUNT, 32'h0000_00FF, 8'd0, 1'b0, STATUS_SUCCESS, 32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd4,   1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0000_1000, 8'd1,   1'b1, STATUS_STACK_FULL, 32'h0},
      '{ROW_WRITE, REG_REGION_BASE, 32'hFFFF_F000, 8'd0, 1'b0, STATUS_SUCCESS, 32'h0},
      '{ROW_ITEM, CMD_FREE,  32'h0000_0000, 8'd1,   1'b1, STATUS_INVALID,    32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd1,   1'b0, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_FREE,  32'hFFFF_F000, 8'd4,   1'b1, STATUS_SUCCESS,    32'h0},
      '{ROW_ITEM, CMD_ALLOC, 32'h0000_0000, 8'd255, 1'b1, STATUS_NO_MEMORY,  32'h0}
   };

   page_frame_allocator_unit #(
      .MAX_PAGES(MAX_PAGES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_page_address(req_page_address),
      .req_page_run(req_page_run),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_result_address(rsp_result_address),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   function automatic void restock_pages();
      for (int i = 0; i < MAX_PAGES; i++) begin
         free_pages[i] = i[6:0];
      end
      page_in_use = '0;
      free_depth = managed_count;
   endfunction

   function automatic void apply_register_write(input logic [2:0] where,
                                                input logic [31:0] value);
      if (where == {REG_REGION_BASE, 2'b00}) begin
         region_base_shadow = value;
      end else if (where == {REG_PAGE_COUNT, 2'b00}) begin
         if (value[7:0] == 8'd0) managed_count = 1;
         else if (value[7:0] > MAX_PAGES) managed_count = MAX_PAGES;
         else managed_count = value[7:0];
         restock_pages();
      end
   endfunction

   function automatic frame_reply_type allocator_reply(input logic cmd,
                                                       input logic [31:0] addr,
                                                       input logic [7:0] run);
      frame_reply_type reply;
      int unsigned     first, streak, i;
      logic [31:0]     offset;
      logic [6:0]      page;
      reply = '{STATUS_NO_MEMORY, 32'h0};
      if (cmd == CMD_ALLOC) begin
         if (run == 8'd0) return reply;
         if (run == 8'd1) begin
            // Stale entries popped on the way stay consumed.
            while (free_depth > 0) begin
               free_depth--;
               page = free_pages[free_depth];
               if (page < managed_count && !page_in_use[page]) begin
                  page_in_use[page] = 1'b1;
                  reply.status = STATUS_SUCCESS;
                  reply.address = region_base_shadow + ({25'd0, page} << PAGE_SHIFT);
                  return reply;
               end
            end
            return reply;
         end
         streak = 0;
         for (i = 0; i < managed_count; i++) begin
            if (page_in_use[i]) begin
               streak = 0;
            end else begin
               streak++;
               if (streak == run) break;
            end
         end
         if (streak != run) return reply;
         first = i + 1 - run;
         for (i = first; i < first + run; i++) page_in_use[i] = 1'b1;
         reply.status = STATUS_SUCCESS;
         reply.address = region_base_shadow + (first << PAGE_SHIFT);
         return reply;
      end
      reply.status = STATUS_INVALID;
      if (addr < region_base_shadow) return reply;
      offset = addr - region_base_shadow;
      first = offset >> PAGE_SHIFT;
      if (first >= managed_count || first + run > managed_count) return reply;
      // Only the first page of the run is tested for a double free.
      if (!page_in_use[first]) begin
         reply.status = STATUS_NOT_IN_USE;
         return reply;
      end
      if (run == 8'd1) begin
         if (free_depth >= managed_count) begin
            reply.status = STATUS_STACK_FULL;
            return reply;
         end
         page_in_use[first] = 1'b0;
         free_pages[free_depth] = first[6:0];
         free_depth++;
      end else begin
         for (i = first; i < first + run; i++) page_in_use[i] = 1'b0;
      end
      reply.status = STATUS_SUCCESS;
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   always @(posedge clock) begin : reply_checker
      frame_reply_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (rsp_status <= STATUS_STACK_FULL) status_seen[rsp_status]++;
            if (owed_replies.size() == 0) begin
               report_mismatch("unexpected reply status", 32'h0, {29'd0, rsp_status});
            end else begin
               want = owed_replies.pop_front();
               replies_checked++;
               if (rsp_status !== want.status)
                  report_mismatch("status", {29'd0, want.status}, {29'd0, rsp_status});
               if (rsp_result_address !== want.address)
                  report_mismatch("result address", want.address, rsp_result_address);
            end
         end
         if (start && !busy) begin
            want = allocator_reply(req_command, req_page_address, req_page_run);
            if (typed_check) want = typed_reply;
            owed_replies.push_back(want);
         end
         if (psel && penable && pwrite && pready) apply_register_write(paddr, pwdata);
      end
   end

   // Starts one transaction and returns at the clock edge that accepts it.
   task automatic issue_request(input logic cmd, input logic [31:0] addr, input logic [7:0] run,
                                input logic by_value, input frame_reply_type value,
                                input int idle_pct);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      typed_check = by_value;
      typed_reply = value;
      start <= 1'b1;
      req_command <= cmd;
      req_page_address <= addr;
      req_page_run <= run;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   task automatic wait_until_settled();
      @(negedge clock);
      start <= 1'b0;
      while (owed_replies.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_register(input logic reg_index, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_applied++;
   endtask

   function automatic int unsigned some_used_page();
      int unsigned probe;
      probe = $urandom_range(managed_count - 1);
      for (int unsigned n = 0; n < managed_count; n++) begin
         if (page_in_use[(probe + n) % managed_count]) return (probe + n) % managed_count;
      end
      return probe;
   endfunction

   // Mostly allocations and frees of pages known to be in use, with some noise.
   task automatic random_request(input int idle_pct);
      int unsigned pick, page, shape;
      logic        cmd;
      logic [31:0] addr;
      logic [7:0]  run;
      pick = $urandom_range(99);
      shape = $urandom_range(99);
      addr = $urandom();
      if (pick < 45) begin
         cmd = CMD_ALLOC;
         if (shape < 55) run = 8'd1;
         else if (shape < 80) run = 8'($urandom_range(4, 2));
         else if (shape < 92) run = 8'($urandom_range(managed_count, 1));
         else if (shape < 96) run = 8'd0;
         else run = 8'($urandom_range(255));
      end else if (pick < 85) begin
         cmd = CMD_FREE;
         page = some_used_page();
         run = (shape < 60) ? 8'd1 : 8'($urandom_range(managed_count - page));
         addr = region_base_shadow + (page << PAGE_SHIFT) + $urandom_range(4095);
      end else begin
         cmd = 1'($urandom_range(1));
         run = 8'($urandom_range(255));
         if (shape < 50)
            addr = region_base_shadow + $urandom_range((managed_count + 2) * 4096 - 1);
      end
      issue_request(cmd, addr, run, 1'b0, '0, idle_pct);
   endtask

   initial begin
      logic [31:0] base_choice;
      logic [31:0] count_word;
      int          idle_pct;
      region_base_shadow = '0;
      managed_count = MAX_PAGES;
      restock_pages();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            wait_until_settled();
            write_register(directed_rows[r].command, directed_rows[r].address);
         end else begin
            issue_request(directed_rows[r].command, directed_rows[r].address,
                          directed_rows[r].run, directed_rows[r].by_value,
                          '{directed_rows[r].status, directed_rows[r].result}, 0);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         idle_pct = (seg < 2) ? 28 : (seg < 4) ? 53 : 0;
         count_word = $urandom();
         case (seg)
            0: begin
               base_choice = 32'h0;
               count_word[7:0] = 8'($urandom_range(16, 4));
            end
            1: begin
               base_choice = $urandom() & 32'h7FFF_F000;
               count_word[7:0] = 8'd128;
            end
            2: begin
               base_choice = 32'hFFFF_FFFF;
               count_word[7:0] = 8'd1;
            end
            3: begin
               base_choice = $urandom();
               count_word[7:0] = 8'($urandom_range(8, 2));
            end
            4: begin
               base_choice = $urandom() & 32'h7FFF_FFFF;
               count_word[7:0] = 8'($urandom_range(40, 8));
            end
            default: begin
               base_choice = 32'h8000_0000;
               count_word[7:0] = 8'd129;
            end
         endcase
         // Registers change only with nothing outstanding.
         wait_until_settled();
         write_register(REG_REGION_BASE, base_choice);
         write_register(REG_PAGE_COUNT, count_word);
         repeat (SEGMENT_ITEMS) begin
            random_request(idle_pct);
            if ($urandom_range(49) == 0) wait_until_settled();
         end
      end

      wait_until_settled();
      // Leave room for a stray reply from the slowest possible request.
      repeat (2 * MAX_PAGES + 50) @(negedge clock);

      $display("Ran %0d allocate/free transactions over %0d register writes; %0d compared.",
               requests_sent, settings_applied, replies_checked);
      $display("Replies: ok %0d, no memory %0d, invalid %0d, not in use %0d, full %0d.",
               status_seen[STATUS_SUCCESS], status_seen[STATUS_NO_MEMORY],
               status_seen[STATUS_INVALID], status_seen[STATUS_NOT_IN_USE],
               status_seen[STATUS_STACK_FULL]);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("Timeout with %0d replies still owed.", owed_replies.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
